>>> hw/rtl/sdsq_pkg.sv
// Package for the SPI-mode SD sector sequencer: phase codes, op and status codes.
// Used by sdsq_core and sd_spi_mode_sector_sequencer_top. No dependencies.
package sdsq_pkg;

	typedef enum logic [5:0] {
		P_IDLE = 6'd0, P_WAKE = 6'd1, P_CMD0 = 6'd2, P_CMD1 = 6'd3, P_CMD12 = 6'd4,
		P_CMD17 = 6'd5, P_CMD18 = 6'd6, P_CMD24 = 6'd7, P_CMD25 = 6'd8, P_CMD32 = 6'd9,
		P_CMD33 = 6'd10, P_CMD38 = 6'd11, P_M_CMD0 = 6'd12, P_M_CMD1 = 6'd13,
		P_M_TOKEN = 6'd14, P_M_CMD24 = 6'd15, P_M_CMD25 = 6'd16, P_M_CMD32 = 6'd17,
		P_M_CMD33 = 6'd18, P_M_CMD38 = 6'd19, P_B_PRE = 6'd20, P_B_BLOCK = 6'd21,
		P_B_STOP = 6'd22, P_RD_DATA = 6'd23, P_RD_CRC = 6'd24, P_W_TOKEN = 6'd25,
		P_W_NEED = 6'd26, P_W_DATA = 6'd27, P_W_CRC = 6'd28, P_W_RESP = 6'd29,
		P_TAIL_SEL = 6'd30, P_TAIL = 6'd31, P_STOP_TOKEN = 6'd32
	} phase_t;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_CARD  = 2'd1;
	localparam logic [1:0] OP_WDATA = 2'd2;

	localparam logic [2:0] K_INIT = 3'd0;
	localparam logic [2:0] K_RD1  = 3'd1;
	localparam logic [2:0] K_RDN  = 3'd2;
	localparam logic [2:0] K_WR1  = 3'd3;
	localparam logic [2:0] K_WRN  = 3'd4;
	localparam logic [2:0] K_ERASE = 3'd5;

	localparam logic [3:0] ST_OK = 4'd0, ST_BUSY_TO = 4'd1, ST_NO_TOKEN = 4'd2,
		ST_RESET_FAIL = 4'd3, ST_INIT_FAIL = 4'd4, ST_WCMD_REJ = 4'd5,
		ST_DATA_REJ = 4'd6, ST_ERASE_START = 4'd7, ST_ERASE_END = 4'd8,
		ST_ERASE_REJ = 4'd9;

	localparam logic [1:0] CFG_MATCH = 2'd0, CFG_BUSY = 2'd1, CFG_RETRY = 2'd2;

	localparam logic [7:0] TOK_START  = 8'hFE;
	localparam logic [7:0] TOK_MULTI  = 8'hFC;
	localparam logic [7:0] TOK_STOP   = 8'hFD;
	localparam logic [7:0] R1_IDLE    = 8'h01;
	localparam logic [7:0] DUMMY      = 8'hFF;
	localparam int         CMD_BYTES  = 6;
	localparam int         SECTOR_BYTES = 512;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       chip_select;
		logic       rd_valid;
		logic [7:0] rd_byte;
		logic       want_data;
		logic       done_res;
		logic [3:0] status;
	} result_t;

	typedef struct packed {
		logic [15:0] match_limit;
		logic [15:0] busy_limit;
		logic [15:0] init_retry_limit;
	} cfg_t;

endpackage

>>> hw/rtl/sdsq_core.sv
// Sequencer state and next-state logic for one transfer per cycle while step is high.
// Depends on sdsq_pkg.
module sdsq_core import sdsq_pkg::*; #(
	parameter int WAKE_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [1:0]  op,
	input  logic [2:0]  kind,
	input  logic [22:0] sector,
	input  logic [15:0] count,
	input  logic [7:0]  card_byte,
	input  logic [7:0]  write_byte,
	input  cfg_t        cfg,
	output result_t     res
);
	phase_t      phase_q, ph_n;
	logic [2:0]  kind_q, kind_n;
	logic [31:0] addr_q, addr_n, end_q, end_n;
	logic [15:0] left_q, left_n, wait_q, wait_n, retry_q, retry_n;
	logic [9:0]  idx_q, idx_n;
	logic [15:0] left_dec, wait_dec;
	logic [31:0] sum32;

	function automatic logic [7:0] cmd_byte(phase_t ph, logic [2:0] i,
		logic [31:0] a, logic [31:0] e);
		logic [7:0]  code, crc;
		logic [31:0] arg;
		code = 8'h40; crc = 8'hFF; arg = '0;
		case (ph)
			P_CMD0:  begin code = 8'h40; crc = 8'h95; end
			P_CMD1:  code = 8'h41;
			P_CMD12: code = 8'h4C;
			P_CMD17: begin code = 8'h51; arg = a; end
			P_CMD18: begin code = 8'h52; arg = a; end
			P_CMD24: begin code = 8'h58; arg = a; end
			P_CMD25: begin code = 8'h59; arg = a; crc = 8'h95; end
			P_CMD32: begin code = 8'h60; arg = a; crc = 8'h95; end
			P_CMD33: begin code = 8'h61; arg = e; crc = 8'h95; end
			P_CMD38: begin code = 8'h66; crc = 8'h95; end
			default: ;
		endcase
		case (i)
			3'd0: return code;
			3'd1: return arg[31:24];
			3'd2: return arg[23:16];
			3'd3: return arg[15:8];
			3'd4: return arg[7:0];
			default: return crc;
		endcase
	endfunction

	assign left_dec = left_q - 16'd1;
	assign wait_dec = wait_q - 16'd1;
	assign sum32 = 32'(sector) + 32'(count) - 32'd1;

	always_comb begin
		ph_n = phase_q; kind_n = kind_q; addr_n = addr_q; end_n = end_q;
		left_n = left_q; wait_n = wait_q; retry_n = retry_q; idx_n = idx_q;
		res = '0;
		if (op == OP_START) begin
			kind_n = kind; addr_n = {sector[22:0], 9'd0}; end_n = {sum32[22:0], 9'd0};
			left_n = count; idx_n = '0; wait_n = '0; retry_n = '0;
			if (kind == K_INIT) begin
				ph_n = P_WAKE; res.tx_valid = 1'b1; res.tx_byte = DUMMY;
			end else if (kind == K_ERASE) begin
				ph_n = P_CMD32; res.tx_valid = 1'b1; res.chip_select = 1'b1;
				res.tx_byte = 8'h60;
			end else if (kind <= K_WRN) begin
				ph_n = P_B_PRE; wait_n = cfg.busy_limit;
				res.tx_valid = 1'b1; res.chip_select = 1'b1; res.tx_byte = DUMMY;
			end else begin
				ph_n = P_IDLE; res.done_res = 1'b1; res.status = ST_OK;
			end
		end else if (op == OP_WDATA) begin
			if (phase_q == P_W_NEED) begin
				ph_n = P_W_DATA; res.tx_valid = 1'b1; res.chip_select = 1'b1;
				res.tx_byte = write_byte;
			end
		end else if (op == OP_CARD) begin
			// Default answer for most branches: a selected dummy transfer.
			res.tx_valid = 1'b1; res.chip_select = 1'b1; res.tx_byte = DUMMY;
			case (phase_q)
				P_IDLE: res = '0;
				P_CMD0, P_CMD1, P_CMD12, P_CMD17, P_CMD18, P_CMD24, P_CMD25,
				P_CMD32, P_CMD33, P_CMD38: begin
					if (idx_q < 10'(CMD_BYTES - 1)) begin
						idx_n = idx_q + 10'd1;
						res.tx_byte = cmd_byte(phase_q, idx_n[2:0], addr_q, end_q);
					end else begin
						wait_n = cfg.match_limit;
						case (phase_q)
							P_CMD0:  ph_n = P_M_CMD0;
							P_CMD1:  ph_n = P_M_CMD1;
							P_CMD12: ph_n = P_TAIL_SEL;
							P_CMD17: ph_n = P_M_TOKEN;
							P_CMD18: begin
								if (left_q == '0) begin
									ph_n = P_CMD12; idx_n = '0; res.tx_byte = 8'h4C;
								end else ph_n = P_M_TOKEN;
							end
							P_CMD24: ph_n = P_M_CMD24;
							P_CMD25: ph_n = P_M_CMD25;
							P_CMD32: ph_n = P_M_CMD32;
							P_CMD33: ph_n = P_M_CMD33;
							default: ph_n = P_M_CMD38;
						endcase
						if (phase_q == P_CMD12 || phase_q == P_CMD18) wait_n = wait_q;
						if (phase_q == P_CMD18 && left_q != '0) wait_n = cfg.match_limit;
					end
				end
				P_M_CMD0, P_M_CMD1, P_M_TOKEN, P_M_CMD24, P_M_CMD25, P_M_CMD32,
				P_M_CMD33, P_M_CMD38: begin
					if (card_byte == (phase_q == P_M_CMD0 ? R1_IDLE :
						(phase_q == P_M_TOKEN ? TOK_START : 8'h00))) begin
						case (phase_q)
							P_M_CMD0: begin
								retry_n = cfg.init_retry_limit; ph_n = P_CMD1;
								idx_n = '0; res.tx_byte = 8'h41;
							end
							P_M_TOKEN: begin ph_n = P_RD_DATA; idx_n = '0; end
							P_M_CMD24: begin ph_n = P_W_TOKEN; res.tx_byte = TOK_START; end
							P_M_CMD25: begin
								wait_n = cfg.busy_limit;
								ph_n = (left_q == '0) ? P_B_STOP : P_B_BLOCK;
							end
							P_M_CMD32: begin
								ph_n = P_CMD33; idx_n = '0; res.tx_byte = 8'h61;
							end
							P_M_CMD33: begin
								ph_n = P_CMD38; idx_n = '0; res.tx_byte = 8'h66;
							end
							default: begin ph_n = P_TAIL; res.chip_select = 1'b0; end
						endcase
					end else if (wait_q == '0) begin
						res = '0; res.done_res = 1'b1; ph_n = P_IDLE;
						case (phase_q)
							P_M_CMD0:  res.status = ST_RESET_FAIL;
							P_M_CMD1: begin
								if (retry_q == '0) res.status = ST_INIT_FAIL;
								else begin
									res = '0; res.tx_valid = 1'b1; res.chip_select = 1'b1;
									res.tx_byte = 8'h41; retry_n = retry_q - 16'd1;
									ph_n = P_CMD1; idx_n = '0;
								end
							end
							P_M_TOKEN: res.status = ST_NO_TOKEN;
							P_M_CMD24, P_M_CMD25: res.status = ST_WCMD_REJ;
							P_M_CMD32: res.status = ST_ERASE_START;
							P_M_CMD33: res.status = ST_ERASE_END;
							default: res.status = ST_ERASE_REJ;
						endcase
					end else wait_n = wait_dec;
				end
				P_B_PRE, P_B_BLOCK, P_B_STOP: begin
					if (card_byte[0]) begin
						idx_n = '0;
						if (phase_q == P_B_BLOCK) begin
							ph_n = P_W_TOKEN; res.tx_byte = TOK_MULTI;
						end else if (phase_q == P_B_STOP) begin
							ph_n = P_STOP_TOKEN; res.tx_byte = TOK_STOP;
						end else begin
							case (kind_q)
								K_RD1: begin ph_n = P_CMD17; res.tx_byte = 8'h51; end
								K_RDN: begin ph_n = P_CMD18; res.tx_byte = 8'h52; end
								K_WR1: begin ph_n = P_CMD24; res.tx_byte = 8'h58; end
								K_WRN: begin ph_n = P_CMD25; res.tx_byte = 8'h59; end
								default: begin
									idx_n = idx_q; res = '0; res.done_res = 1'b1;
									ph_n = P_IDLE;
								end
							endcase
						end
					end else begin
						wait_n = wait_dec;
						if (wait_dec == '0) begin
							res = '0; res.done_res = 1'b1; res.status = ST_BUSY_TO;
							ph_n = P_IDLE;
						end
					end
				end
				P_WAKE: begin
					idx_n = idx_q + 10'd1;
					if (idx_n < 10'(WAKE_BYTES)) res.chip_select = 1'b0;
					else begin ph_n = P_CMD0; idx_n = '0; res.tx_byte = 8'h40; end
				end
				P_RD_DATA: begin
					res.rd_valid = 1'b1; res.rd_byte = card_byte;
					idx_n = idx_q + 10'd1;
					if (idx_q == 10'(SECTOR_BYTES - 1)) begin
						ph_n = P_RD_CRC; idx_n = '0;
					end
				end
				P_RD_CRC: begin
					if (idx_q == '0) idx_n = 10'd1;
					else if (kind_q != K_RDN) begin
						res = '0; res.done_res = 1'b1; ph_n = P_IDLE;
					end else begin
						left_n = left_dec;
						if (left_dec == '0) begin
							ph_n = P_CMD12; idx_n = '0; res.tx_byte = 8'h4C;
						end else begin
							ph_n = P_M_TOKEN; wait_n = cfg.match_limit;
						end
					end
				end
				P_W_TOKEN, P_W_NEED: begin
					if (phase_q == P_W_TOKEN) idx_n = '0;
					ph_n = P_W_NEED;
					res = '0; res.chip_select = 1'b1; res.want_data = 1'b1;
				end
				P_W_DATA: begin
					idx_n = idx_q + 10'd1;
					if (idx_q != 10'(SECTOR_BYTES - 1)) begin
						ph_n = P_W_NEED;
						res = '0; res.chip_select = 1'b1; res.want_data = 1'b1;
					end else begin
						ph_n = P_W_CRC; idx_n = '0;
					end
				end
				P_W_CRC: begin
					if (idx_q == '0) idx_n = 10'd1; else ph_n = P_W_RESP;
				end
				P_W_RESP: begin
					if (kind_q != K_WRN) begin
						if (card_byte[3:0] != 4'h5) begin
							res = '0; res.done_res = 1'b1; res.status = ST_DATA_REJ;
							ph_n = P_IDLE;
						end else begin ph_n = P_TAIL; res.chip_select = 1'b0; end
					end else if (card_byte[4:0] != 5'h05) begin
						res = '0; res.done_res = 1'b1; res.status = ST_DATA_REJ;
						ph_n = P_IDLE;
					end else begin
						left_n = left_dec; wait_n = cfg.busy_limit;
						ph_n = (left_dec == '0) ? P_B_STOP : P_B_BLOCK;
					end
				end
				P_TAIL_SEL: begin ph_n = P_TAIL; res.chip_select = 1'b0; end
				P_TAIL, P_STOP_TOKEN: begin
					res = '0; res.done_res = 1'b1; ph_n = P_IDLE;
				end
				default: res = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; kind_q <= '0; addr_q <= '0; end_q <= '0;
			left_q <= '0; wait_q <= '0; retry_q <= '0; idx_q <= '0;
		end else if (step) begin
			phase_q <= ph_n; kind_q <= kind_n; addr_q <= addr_n; end_q <= end_n;
			left_q <= left_n; wait_q <= wait_n; retry_q <= retry_n; idx_q <= idx_n;
		end
	end

	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_RD_DATA || phase_q == P_W_NEED || phase_q == P_W_DATA ||
		idx_q < 10'd32)
		else $error("byte index out of range outside data phases");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == P_IDLE)
		else $error("phase not idle after done");
	a_want_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.want_data && res.tx_valid))
		else $error("want_data with an exchange");
endmodule

>>> hw/rtl/sd_spi_mode_sector_sequencer_top.sv
// Top level of the SPI-mode SD sector sequencer: config registers, output register.
// Depends on sdsq_pkg and sdsq_core.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, op..write_byte        | item into the block
//  out     | out_valid/out_ready, tx_valid..status    | one result per item
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | register write
//
// The core's next-state logic sits between state and the result register. A new
// item is accepted every cycle while the result register is empty or being taken.
// Reset clears state and loads register defaults.
// A stalled output holds the result and stops further transfers.
module sd_spi_mode_sector_sequencer_top import sdsq_pkg::*; #(
	parameter int WAKE_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  kind,
	input  logic [22:0] sector,
	input  logic [15:0] count,
	input  logic [7:0]  card_byte,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        chip_select,
	output logic        rd_valid,
	output logic [7:0]  rd_byte,
	output logic        want_data,
	output logic        done_res,
	output logic [3:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	cfg_t    cfg_q;
	result_t res_c, res_q;
	logic    step;

	assign in_ready  = !out_valid || out_ready;
	assign step      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	sdsq_core #(.WAKE_BYTES(WAKE_BYTES)) u_core (
		.clk, .arst_n, .step, .op, .kind, .sector, .count, .card_byte, .write_byte,
		.cfg(cfg_q), .res(res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_limit <= 16'd20000;
			cfg_q.busy_limit <= 16'hFFFF;
			cfg_q.init_retry_limit <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MATCH: cfg_q.match_limit <= cfg_data;
				CFG_BUSY:  cfg_q.busy_limit <= cfg_data;
				CFG_RETRY: cfg_q.init_retry_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res_c;
	end

	assign tx_valid = res_q.tx_valid;
	assign tx_byte = res_q.tx_byte;
	assign chip_select = res_q.chip_select;
	assign rd_valid = res_q.rd_valid;
	assign rd_byte = res_q.rd_byte;
	assign want_data = res_q.want_data;
	assign done_res = res_q.done_res;
	assign status = res_q.status;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("result changed while stalled");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted item produced no result");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK)
		else $error("status without done");
endmodule

>>> tb/sdsq_checker.sv
`timescale 1ns / 1ps
// Checker for the SPI-mode SD sector sequencer: watches the item, result and register channels,
// predicts every result and compares it field by field. Depends on sdsq_pkg.
module sdsq_checker import sdsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  kind,
	input  logic [22:0] sector,
	input  logic [15:0] count,
	input  logic [7:0]  card_byte,
	input  logic [7:0]  write_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        chip_select,
	input  logic        rd_valid,
	input  logic [7:0]  rd_byte,
	input  logic        want_data,
	input  logic        done_res,
	input  logic [3:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending
);
	localparam int WAKE_COUNT = 10;

	phase_t      seq_phase;
	logic [2:0]  cur_kind;
	logic [31:0] first_addr, last_addr;
	logic [15:0] sectors_todo;
	int unsigned byte_pos;
	logic [15:0] wait_left, retries_left;
	logic [15:0] lim_match, lim_busy, lim_retry;
	result_t     nxt;
	result_t     expected_results[$];

	function automatic logic [7:0] cmd_at(phase_t p, int unsigned i);
		logic [7:0]  codes [10];
		int unsigned k;
		logic [31:0] arg;
		codes = '{8'd0, 8'd1, 8'd12, 8'd17, 8'd18, 8'd24, 8'd25, 8'd32, 8'd33, 8'd38};
		k = p - P_CMD0;
		if (i == 0)
			return 8'h40 | codes[k];
		if (i >= 5)
			return (k == 0 || k >= 6) ? 8'h95 : DUMMY;
		arg = (k >= 3 && k <= 7) ? first_addr : (k == 8 ? last_addr : 32'd0);
		return 8'(arg >> ((4 - i) * 8));
	endfunction

	function automatic void send(logic [7:0] b, logic cs);
		nxt.tx_valid = 1'b1;
		nxt.tx_byte = b;
		nxt.chip_select = cs;
	endfunction

	function automatic void ask_data();
		nxt.chip_select = 1'b1;
		nxt.want_data = 1'b1;
	endfunction

	function automatic void finish_op(logic [3:0] st);
		seq_phase = P_IDLE;
		nxt.tx_valid = 1'b0;
		nxt.tx_byte = '0;
		nxt.chip_select = 1'b0;
		nxt.want_data = 1'b0;
		nxt.done_res = 1'b1;
		nxt.status = st;
	endfunction

	function automatic void begin_cmd(phase_t p);
		seq_phase = p;
		byte_pos = 0;
		send(cmd_at(p, 0), 1'b1);
	endfunction

	function automatic void begin_match(phase_t p);
		seq_phase = p;
		wait_left = lim_match;
		send(DUMMY, 1'b1);
	endfunction

	function automatic void begin_busy(phase_t p);
		seq_phase = p;
		wait_left = lim_busy;
		send(DUMMY, 1'b1);
	endfunction

	function automatic void cmd_sent();
		case (seq_phase)
			P_CMD0: begin_match(P_M_CMD0);
			P_CMD1: begin_match(P_M_CMD1);
			P_CMD12: begin
				seq_phase = P_TAIL_SEL;
				send(DUMMY, 1'b1);
			end
			P_CMD17: begin_match(P_M_TOKEN);
			P_CMD18: if (sectors_todo == 0) begin_cmd(P_CMD12); else begin_match(P_M_TOKEN);
			P_CMD24: begin_match(P_M_CMD24);
			P_CMD25: begin_match(P_M_CMD25);
			P_CMD32: begin_match(P_M_CMD32);
			P_CMD33: begin_match(P_M_CMD33);
			default: begin_match(P_M_CMD38);
		endcase
	endfunction

	function automatic void response_seen();
		case (seq_phase)
			P_M_CMD0: begin
				retries_left = lim_retry;
				begin_cmd(P_CMD1);
			end
			P_M_TOKEN: begin
				seq_phase = P_RD_DATA;
				byte_pos = 0;
				send(DUMMY, 1'b1);
			end
			P_M_CMD24: begin
				seq_phase = P_W_TOKEN;
				send(TOK_START, 1'b1);
			end
			P_M_CMD25: if (sectors_todo == 0) begin_busy(P_B_STOP); else begin_busy(P_B_BLOCK);
			P_M_CMD32: begin_cmd(P_CMD33);
			P_M_CMD33: begin_cmd(P_CMD38);
			default: begin
				seq_phase = P_TAIL;
				send(DUMMY, 1'b0);
			end
		endcase
	endfunction

	function automatic void response_timeout();
		case (seq_phase)
			P_M_CMD0: finish_op(ST_RESET_FAIL);
			P_M_CMD1: begin
				if (retries_left == 0) begin
					finish_op(ST_INIT_FAIL);
				end else begin
					retries_left--;
					begin_cmd(P_CMD1);
				end
			end
			P_M_TOKEN: finish_op(ST_NO_TOKEN);
			P_M_CMD24, P_M_CMD25: finish_op(ST_WCMD_REJ);
			P_M_CMD32: finish_op(ST_ERASE_START);
			P_M_CMD33: finish_op(ST_ERASE_END);
			default: finish_op(ST_ERASE_REJ);
		endcase
	endfunction

	function automatic void card_released();
		if (seq_phase == P_B_BLOCK) begin
			seq_phase = P_W_TOKEN;
			send(TOK_MULTI, 1'b1);
		end else if (seq_phase == P_B_STOP) begin
			seq_phase = P_STOP_TOKEN;
			send(TOK_STOP, 1'b1);
		end else begin
			case (cur_kind)
				K_RD1: begin_cmd(P_CMD17);
				K_RDN: begin_cmd(P_CMD18);
				K_WR1: begin_cmd(P_CMD24);
				K_WRN: begin_cmd(P_CMD25);
				default: finish_op(ST_OK);
			endcase
		end
	endfunction

	function automatic void start_op(logic [2:0] k, logic [22:0] sec, logic [15:0] cnt);
		logic [31:0] last_sec;
		last_sec = {9'd0, sec} + {16'd0, cnt} - 32'd1;
		cur_kind = k;
		first_addr = {sec, 9'd0};
		last_addr = last_sec << 9;
		sectors_todo = cnt;
		byte_pos = 0;
		wait_left = '0;
		retries_left = '0;
		if (k == K_INIT) begin
			seq_phase = P_WAKE;
			send(DUMMY, 1'b0);
		end else if (k >= K_RD1 && k <= K_WRN) begin
			begin_busy(P_B_PRE);
		end else if (k == K_ERASE) begin
			begin_cmd(P_CMD32);
		end else begin
			finish_op(ST_OK);
		end
	endfunction

	function automatic void card_returned(logic [7:0] b);
		logic [7:0] want_b;
		if (seq_phase >= P_CMD0 && seq_phase <= P_CMD38) begin
			if (byte_pos < CMD_BYTES - 1) begin
				byte_pos++;
				send(cmd_at(seq_phase, byte_pos), 1'b1);
			end else begin
				cmd_sent();
			end
		end else if (seq_phase >= P_M_CMD0 && seq_phase <= P_M_CMD38) begin
			want_b = seq_phase == P_M_CMD0 ? R1_IDLE :
				(seq_phase == P_M_TOKEN ? TOK_START : 8'h00);
			if (b == want_b) begin
				response_seen();
			end else if (wait_left == 0) begin
				response_timeout();
			end else begin
				wait_left--;
				send(DUMMY, 1'b1);
			end
		end else if (seq_phase >= P_B_PRE && seq_phase <= P_B_STOP) begin
			if (b[0]) begin
				card_released();
			end else begin
				wait_left--;
				if (wait_left == 0) finish_op(ST_BUSY_TO); else send(DUMMY, 1'b1);
			end
		end else begin
			case (seq_phase)
				P_WAKE: begin
					byte_pos++;
					if (byte_pos < WAKE_COUNT) send(DUMMY, 1'b0); else begin_cmd(P_CMD0);
				end
				P_RD_DATA: begin
					nxt.rd_valid = 1'b1;
					nxt.rd_byte = b;
					byte_pos++;
					if (byte_pos >= SECTOR_BYTES) begin
						seq_phase = P_RD_CRC;
						byte_pos = 0;
					end
					send(DUMMY, 1'b1);
				end
				P_RD_CRC: begin
					if (byte_pos == 0) begin
						byte_pos = 1;
						send(DUMMY, 1'b1);
					end else if (cur_kind != K_RDN) begin
						finish_op(ST_OK);
					end else begin
						sectors_todo--;
						if (sectors_todo == 0) begin_cmd(P_CMD12); else begin_match(P_M_TOKEN);
					end
				end
				P_W_TOKEN: begin
					byte_pos = 0;
					seq_phase = P_W_NEED;
					ask_data();
				end
				P_W_NEED: ask_data();
				P_W_DATA: begin
					byte_pos++;
					if (byte_pos < SECTOR_BYTES) begin
						seq_phase = P_W_NEED;
						ask_data();
					end else begin
						seq_phase = P_W_CRC;
						byte_pos = 0;
						send(DUMMY, 1'b1);
					end
				end
				P_W_CRC: begin
					if (byte_pos == 0) byte_pos = 1; else seq_phase = P_W_RESP;
					send(DUMMY, 1'b1);
				end
				P_W_RESP: begin
					if (cur_kind != K_WRN) begin
						if (b[3:0] != 4'h5) begin
							finish_op(ST_DATA_REJ);
						end else begin
							seq_phase = P_TAIL;
							send(DUMMY, 1'b0);
						end
					end else if (b[4:0] != 5'h05) begin
						finish_op(ST_DATA_REJ);
					end else begin
						sectors_todo--;
						if (sectors_todo == 0) begin_busy(P_B_STOP); else begin_busy(P_B_BLOCK);
					end
				end
				P_TAIL_SEL: begin
					seq_phase = P_TAIL;
					send(DUMMY, 1'b0);
				end
				P_TAIL, P_STOP_TOKEN: finish_op(ST_OK);
				default: ;
			endcase
		end
	endfunction

	function automatic result_t next_exchange();
		nxt = '0;
		if (op == OP_START) begin
			start_op(kind, sector, count);
		end else if (op == OP_CARD) begin
			card_returned(card_byte);
		end else if (op == OP_WDATA && seq_phase == P_W_NEED) begin
			seq_phase = P_W_DATA;
			send(write_byte, 1'b1);
		end
		return nxt;
	endfunction

	task automatic report(string field, logic [7:0] got, logic [7:0] want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			seq_phase = P_IDLE;
			cur_kind = '0;
			first_addr = '0;
			last_addr = '0;
			sectors_todo = '0;
			byte_pos = 0;
			wait_left = '0;
			retries_left = '0;
			lim_match = 16'd20000;
			lim_busy = 16'hFFFF;
			lim_retry = 16'd100;
			expected_results.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $realtime);
					fails++;
				end else begin
					e = expected_results.pop_front();
					if (tx_valid !== e.tx_valid) report("tx_valid", tx_valid, e.tx_valid);
					if (tx_byte !== e.tx_byte) report("tx_byte", tx_byte, e.tx_byte);
					if (chip_select !== e.chip_select)
						report("chip_select", chip_select, e.chip_select);
					if (rd_valid !== e.rd_valid) report("rd_valid", rd_valid, e.rd_valid);
					if (rd_byte !== e.rd_byte) report("rd_byte", rd_byte, e.rd_byte);
					if (want_data !== e.want_data) report("want_data", want_data, e.want_data);
					if (done_res !== e.done_res) report("done_res", done_res, e.done_res);
					if (status !== e.status) report("status", status, e.status);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(next_exchange());
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MATCH: lim_match = cfg_data;
					CFG_BUSY: lim_busy = cfg_data;
					CFG_RETRY: lim_retry = cfg_data;
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the SPI-mode SD sector sequencer regression.
// Depends on sdsq_pkg, sd_spi_mode_sector_sequencer_top and sdsq_checker.
module tb;
	import sdsq_pkg::*;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0]  op, cfg_index;
	logic [2:0]  kind;
	logic [22:0] sector;
	logic [15:0] count, cfg_data;
	logic [7:0]  card_byte, write_byte, tx_byte, rd_byte;
	logic        tx_valid, chip_select, rd_valid, want_data, done_res;
	logic [3:0]  status;
	int          fails, pending, quiet_cycles;
	logic        hold_out, last_want;

	sd_spi_mode_sector_sequencer_top uut (.*);
	sdsq_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic [1:0] o, logic [2:0] k, logic [22:0] s, logic [15:0] c,
			logic [7:0] cb, logic [7:0] wb);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		op = o;
		kind = k;
		sector = s;
		count = c;
		card_byte = cb;
		write_byte = wb;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let every expected result drain, then wait for the result register.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] card_reply();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return R1_IDLE;
			2: return TOK_START;
			3: return DUMMY;
			4: return 8'h05;
			5: return 8'hE5;
			6: return 8'h0D;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_item();
		int r;
		logic [22:0] s;
		logic [15:0] c;
		r = $urandom_range(0, 999);
		s = $urandom_range(0, 3) == 0 ? 23'h7FFFFF : 23'($urandom());
		case ($urandom_range(0, 9))
			0: c = 16'hFFFF;
			1: c = 16'($urandom());
			default: c = 16'($urandom_range(0, 3));
		endcase
		if (r < 8)
			send_item(OP_START, 3'($urandom_range(0, 7)), s, c, 8'($urandom()),
				8'($urandom()));
		else if (last_want && r < 850)
			send_item(OP_WDATA, 3'($urandom()), s, c, 8'($urandom()), 8'($urandom()));
		else if (r < 20)
			send_item(2'd3, 3'($urandom()), s, c, 8'($urandom()), 8'($urandom()));
		else if (r < 60)
			send_item(OP_WDATA, 3'($urandom()), s, c, 8'($urandom()), 8'($urandom()));
		else
			send_item(OP_CARD, 3'($urandom()), s, c, card_reply(), 8'($urandom()));
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_out = 1'b0;
			end else begin
				out_ready = pick_gap() == 0;
			end
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			last_want <= want_data;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("sd_spi_mode_sector_sequencer_top regression: fail");
			$finish;
		end
	end

	initial begin
		logic [15:0] settings [5][3];
		settings = '{'{16'd0, 16'd1, 16'd0}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{16'd3, 16'd2, 16'd2}, '{16'd1, 16'd20, 16'd4}, '{16'd20000, 16'hFFFF, 16'd100}};
		settings[3][0] = 16'($urandom_range(0, 8));
		settings[3][1] = 16'($urandom_range(1, 20));
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		op = '0;
		kind = '0;
		sector = '0;
		count = '0;
		card_byte = '0;
		write_byte = '0;
		cfg_index = '0;
		cfg_data = '0;
		hold_out = 1'b0;
		last_want = 1'b0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Out-of-turn items while idle, unknown kinds, then each operation kind, some at the field extremes.
		send_item(OP_CARD, K_INIT, 23'd0, 16'd0, 8'hFF, 8'h00);
		send_item(OP_WDATA, K_INIT, 23'd0, 16'd0, 8'h00, 8'hFF);
		send_item(2'd3, K_INIT, 23'd0, 16'd0, 8'h00, 8'h00);
		send_item(OP_START, 3'd6, 23'd0, 16'd0, 8'h00, 8'h00);
		send_item(OP_START, 3'd7, 23'h7FFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		send_item(OP_START, K_INIT, 23'd0, 16'd0, 8'h00, 8'h00);
		repeat (3) send_item(OP_CARD, K_INIT, 23'd0, 16'd0, 8'hFF, 8'h00);
		send_item(OP_START, K_ERASE, 23'd0, 16'd0, 8'h00, 8'h00);
		repeat (7) send_item(OP_CARD, K_INIT, 23'd0, 16'd0, 8'hFF, 8'h00);
		send_item(OP_START, K_ERASE, 23'h7FFFFF, 16'hFFFF, 8'h00, 8'h00);
		repeat (3) send_item(OP_CARD, K_INIT, 23'd0, 16'd0, 8'h00, 8'h00);
		send_item(OP_START, K_RDN, 23'h7FFFFF, 16'd0, 8'h00, 8'h00);
		send_item(OP_START, K_WRN, 23'd1, 16'd0, 8'h00, 8'h00);
		send_item(OP_START, K_RD1, 23'd5, 16'd1, 8'h00, 8'h00);
		send_item(OP_START, K_WR1, 23'd9, 16'd2, 8'h00, 8'h00);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_MATCH, settings[p][0]);
			write_reg(CFG_BUSY, settings[p][1]);
			write_reg(CFG_RETRY, settings[p][2]);
			for (int i = 0; i < 300; i++) begin
				if (p == 2 && i == 100)
					hold_out = 1'b1;
				random_item();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("sd_spi_mode_sector_sequencer_top regression: pass");
		else
			$display("sd_spi_mode_sector_sequencer_top regression: fail");
		$finish;
	end
endmodule

>>> sd_spi_mode_sector_sequencer_top.f
hw/rtl/sdsq_pkg.sv
hw/rtl/sdsq_core.sv
hw/rtl/sd_spi_mode_sector_sequencer_top.sv
tb/sdsq_checker.sv
tb/tb.sv
